// ===== hdl/framed_packet_receiver_core_defines.svh =====
// Assertion macros shared by the checker of the framed packet receiver core.
// Depends on nothing; included by name by the files that assert.
`ifndef FRAMED_PACKET_RECEIVER_CORE_DEFINES_SVH
`define FRAMED_PACKET_RECEIVER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("framed packet receiver: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("framed packet receiver: next-cycle check failed");

`endif

// ===== hdl/fpr_pkg.sv =====
// Package of the framed packet receiver: result kinds, result record and reset constants.
// Depends on nothing; used by the interfaces, the sub-modules and the top level.
package fpr_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hF9;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_GOOD    = 2'd1,
      KIND_BAD     = 2'd2
   } kind_type;

   // One result as produced by the parser for the output register.
   typedef struct packed {
      logic              emit;
      kind_type          kind;
      logic [BYTE_W-1:0] payload;
      logic              frame_end;
   } result_type;

endpackage

// ===== hdl/fpr_req_if.sv =====
// Input channel of the framed packet receiver: one received byte per transfer.
// Depends on fpr_pkg.
interface fpr_req_if;
   logic                         valid;
   logic                         ready;
   logic [fpr_pkg::BYTE_W-1:0]   rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/fpr_rsp_if.sv =====
// Result channel of the framed packet receiver: payload bytes and end-of-frame status.
// Depends on fpr_pkg.
interface fpr_rsp_if;
   logic                         valid;
   logic                         ready;
   fpr_pkg::kind_type            result_kind;
   logic [fpr_pkg::BYTE_W-1:0]   payload_byte;
   logic                         frame_end;

   modport source (output valid, output result_kind, output payload_byte, output frame_end,
                   input ready);
   modport sink   (input valid, input result_kind, input payload_byte, input frame_end,
                   output ready);
endinterface

// ===== hdl/fpr_parser.sv =====
// Frame parser: phase state machine, length counter and Fletcher-8 running sums.
// Depends on fpr_pkg.
module fpr_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [fpr_pkg::BYTE_W-1:0]   rx_byte,
   input  logic [fpr_pkg::BYTE_W-1:0]   header,
   output fpr_pkg::result_type          result
);

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_LEN  = 3'd1,
      PH_DATA = 3'd2,
      PH_CHKA = 3'd3,
      PH_CHKB = 3'd4
   } phase_type;

   phase_type                    phase_ff, phase_in;
   logic [fpr_pkg::BYTE_W-1:0]   bytes_left_ff, bytes_left_in;
   logic [fpr_pkg::BYTE_W-1:0]   sum_a_ff, sum_a_in;
   logic [fpr_pkg::BYTE_W-1:0]   sum_b_ff, sum_b_in;
   logic [fpr_pkg::BYTE_W-1:0]   check_a_ff, check_a_in;

   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      sum_a_in      = sum_a_ff;
      sum_b_in      = sum_b_ff;
      check_a_in    = check_a_ff;
      result        = '0;
      result.kind   = fpr_pkg::KIND_PAYLOAD;
      unique case (phase_ff)
         PH_LEN: begin
            bytes_left_in = rx_byte;
            sum_a_in      = '0;
            sum_b_in      = '0;
            phase_in      = (rx_byte == '0) ? PH_CHKA : PH_DATA;
         end
         PH_DATA: begin
            sum_a_in      = sum_a_ff + rx_byte;
            sum_b_in      = sum_b_ff + sum_a_in;
            bytes_left_in = bytes_left_ff - 1'b1;
            if (bytes_left_in == '0) begin
               phase_in = PH_CHKA;
            end
            result.emit    = accept;
            result.kind    = fpr_pkg::KIND_PAYLOAD;
            result.payload = rx_byte;
         end
         PH_CHKA: begin
            check_a_in = rx_byte;
            phase_in   = PH_CHKB;
         end
         PH_CHKB: begin
            phase_in         = PH_HUNT;
            result.emit      = accept;
            result.kind      = ((check_a_ff == sum_a_ff) && (rx_byte == sum_b_ff)) ?
                               fpr_pkg::KIND_GOOD : fpr_pkg::KIND_BAD;
            result.frame_end = 1'b1;
         end
         default: begin
            phase_in = (rx_byte == header) ? PH_LEN : PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         bytes_left_ff <= '0;
         sum_a_ff      <= '0;
         sum_b_ff      <= '0;
         check_a_ff    <= '0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         sum_a_ff      <= sum_a_in;
         sum_b_ff      <= sum_b_in;
         check_a_ff    <= check_a_in;
      end
   end

endmodule

// ===== hdl/fpr_out_stage.sv =====
// Output register of the framed packet receiver, holding one result for the sink.
// Depends on fpr_pkg.
module fpr_out_stage (
   input  logic                         clock,
   input  logic                         reset,
   input  fpr_pkg::result_type          result,
   output logic                         can_accept,
   output logic                         out_valid,
   input  logic                         out_ready,
   output fpr_pkg::kind_type            out_kind,
   output logic [fpr_pkg::BYTE_W-1:0]   out_payload,
   output logic                         out_frame_end
);

   logic                         valid_ff;
   fpr_pkg::kind_type            kind_ff;
   logic [fpr_pkg::BYTE_W-1:0]   payload_ff;
   logic                         frame_end_ff;

   // The register may take a new result when it is empty or being emptied now.
   assign can_accept = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (result.emit) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result.emit) begin
         kind_ff      <= result.kind;
         payload_ff   <= result.payload;
         frame_end_ff <= result.frame_end;
      end
   end

   assign out_valid     = valid_ff;
   assign out_kind      = kind_ff;
   assign out_payload   = payload_ff;
   assign out_frame_end = frame_end_ff;

endmodule

// ===== hdl/framed_packet_receiver_core.sv =====
// Top level of the framed packet receiver: header register, parser and output register.
// Depends on fpr_pkg, fpr_req_if, fpr_rsp_if, fpr_parser and fpr_out_stage.
//
//   channel   direction  transfer carries
//   req_chan  in         rx_byte, one received byte
//   rsp_chan  out        result_kind, payload_byte, frame_end
//   csr_*     in         header_value write (csr_we, csr_wdata)
//
// Each byte is parsed by the phase logic as it is accepted and any result lands in the
// output register at the same clock edge, so one byte per cycle is sustained while
// rsp_chan takes each result. A payload byte appears on rsp_chan in the cycle after its
// transfer. Synchronous reset returns the parser to hunting, the header to 0xF9 and
// empties the output register. While a result waits un-taken, req_chan.ready stays low.
module framed_packet_receiver_core (
   input  logic                         clock,
   input  logic                         reset,
   fpr_req_if.sink                      req_chan,
   fpr_rsp_if.source                    rsp_chan,
   input  logic                         csr_we,
   input  logic [fpr_pkg::BYTE_W-1:0]   csr_wdata
);

   logic [fpr_pkg::BYTE_W-1:0]   header_ff;
   logic                         can_accept;
   logic                         accept;
   fpr_pkg::result_type          result;

   // The header value takes effect at the next byte examined while hunting.
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= fpr_pkg::HEADER_RESET;
      end else if (csr_we) begin
         header_ff <= csr_wdata;
      end
   end

   // A byte is taken whenever the output register can hold whatever it may produce.
   assign req_chan.ready = can_accept;
   assign accept         = req_chan.valid && can_accept;

   fpr_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_chan.rx_byte),
      .header  (header_ff),
      .result  (result)
   );

   fpr_out_stage u_out (
      .clock         (clock),
      .reset         (reset),
      .result        (result),
      .can_accept    (can_accept),
      .out_valid     (rsp_chan.valid),
      .out_ready     (rsp_chan.ready),
      .out_kind      (rsp_chan.result_kind),
      .out_payload   (rsp_chan.payload_byte),
      .out_frame_end (rsp_chan.frame_end)
   );

endmodule

// ===== hdl/fpr_checker.sv =====
// Port-level checker of the framed packet receiver, bound to the top level.
// Depends on fpr_pkg and framed_packet_receiver_core_defines.svh.
`include "framed_packet_receiver_core_defines.svh"

module fpr_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_ready,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  fpr_pkg::kind_type            rsp_kind,
   input  logic [fpr_pkg::BYTE_W-1:0]   rsp_payload,
   input  logic                         rsp_frame_end
);

   // A held result keeps its contents until it is taken.
   `FPR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_payload) && $stable(rsp_frame_end))

   // Only end-of-frame results carry a status kind, and they carry no byte.
   `FPR_ASSERT_SAME(a_end_kind, clock, reset, rsp_valid, rsp_frame_end == (rsp_kind != fpr_pkg::KIND_PAYLOAD))
   `FPR_ASSERT_SAME(a_end_zero, clock, reset, rsp_valid && rsp_frame_end, rsp_payload == '0)

   // Input is held off exactly while a result waits un-taken.
   `FPR_ASSERT_SAME(a_stall, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   `FPR_ASSERT_SAME(a_free, clock, reset, !rsp_valid || rsp_ready, req_ready)

endmodule

bind framed_packet_receiver_core fpr_checker u_fpr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_kind      (rsp_chan.result_kind),
   .rsp_payload   (rsp_chan.payload_byte),
   .rsp_frame_end (rsp_chan.frame_end)
);
